// ----- rtl/core/dapid_pkg.sv -----
// Package for the dual axis position PID unit.
// Widths, register codes, reset values and shared item types.
// No dependencies.
package dapid_pkg;

	localparam int GAIN_W  = 24;
	localparam int LIM_W   = 15;
	localparam int TICK_W  = 16;
	localparam int ERR_W   = 16;
	localparam int TGT_W   = 14;
	localparam int DRV_W   = 16;
	localparam int CFG_DW  = 24;
	localparam int CFG_IW  = 3;
	localparam int PROD_W  = 41;
	localparam int SUM_W   = 43;

	localparam int OUT_DEPTH_DEF = 8;

	localparam logic [GAIN_W-1:0] KP_RST      = 24'd78643;
	localparam logic [GAIN_W-1:0] KI_RST      = 24'd7;
	localparam logic [GAIN_W-1:0] KD_RST      = 24'd65536;
	localparam logic [LIM_W-1:0]  LIMIT_RST   = 15'd400;
	localparam logic [LIM_W-1:0]  TOL_RST     = 15'd15;
	localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd1000;

	typedef enum logic [CFG_IW-1:0] {
		REG_KP      = 3'd0,
		REG_KI      = 3'd1,
		REG_KD      = 3'd2,
		REG_LIMIT   = 3'd3,
		REG_TOL     = 3'd4,
		REG_TIMEOUT = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		CMD_START  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic clr;
		logic upd;
	} lane_ctl_t;

	typedef struct packed {
		logic done;
		logic tmo;
		logic clr;
		logic moving;
		logic run;
	} res_flags_t;

	typedef struct packed {
		logic signed [DRV_W-1:0] drive_left;
		logic signed [DRV_W-1:0] drive_right;
		res_flags_t              flags;
	} res_t;

endpackage

// ----- rtl/core/dapid_lane.sv -----
// One wheel lane: error, gain products, integral recurrence, drive sum and clamp.
// Uses dapid_pkg; controlled by dapid_ctrl through a lane_ctl_t.
module dapid_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load_goal,
	input  logic signed [dapid_pkg::TGT_W-1:0]  target,
	input  logic signed [dapid_pkg::ERR_W-1:0]  enc,
	input  logic        [dapid_pkg::GAIN_W-1:0] kp,
	input  logic        [dapid_pkg::GAIN_W-1:0] ki,
	input  logic        [dapid_pkg::GAIN_W-1:0] kd,
	input  logic        [dapid_pkg::LIM_W-1:0]  tol,
	input  logic        [dapid_pkg::LIM_W-1:0]  limit,
	input  dapid_pkg::lane_ctl_t                ctl,
	output logic                                within_s2,
	output logic signed [dapid_pkg::DRV_W-1:0]  drive_s4
);

	function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
		if (v > 28'sd32767) begin
			return 16'sh7fff;
		end else if (v < -28'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

	logic signed [15:0] goal_q;
	logic signed [16:0] diff;
	logic signed [15:0] err0;
	logic signed [15:0] err_s1;

	logic signed [dapid_pkg::PROD_W-1:0] pi_c, pp_c, pd_c;
	logic signed [16:0] err_x, tol_x;
	logic within_c;

	logic signed [dapid_pkg::PROD_W-1:0] pi_s2, pp_s2, pd_s2;
	logic signed [15:0] err_s2;
	logic signed [15:0] integ_q;
	logic signed [15:0] last_q;
	logic signed [dapid_pkg::PROD_W-1:0] kdl_c;
	logic signed [24:0] frac_hi;
	logic signed [25:0] iq, iq_r;
	logic               i_inc;
	logic signed [15:0] integ_new;

	logic signed [15:0] integ_s3;
	logic signed [dapid_pkg::PROD_W-1:0] pp_s3, pd_s3, kdl_s3;
	logic signed [dapid_pkg::SUM_W-1:0] sum_c;
	logic signed [dapid_pkg::SUM_W-1:0] sum_s4;

	logic signed [26:0] dq;
	logic signed [27:0] dq_r, lim_x;
	logic               d_inc;

	// stage 0: error against the current goal
	assign diff = {goal_q[15], goal_q} - {enc[15], enc};
	assign err0 = sat16($signed({{11{diff[16]}}, diff}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q <= '0;
		end else if (load_goal) begin
			goal_q <= {target, 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		err_s1 <= err0;
	end

	// stage 1: gain products and settle check
	assign pi_c = $signed({1'b0, ki}) * err_s1;
	assign pp_c = $signed({1'b0, kp}) * err_s1;
	assign pd_c = $signed({1'b0, kd}) * err_s1;
	assign err_x = {err_s1[15], err_s1};
	assign tol_x = $signed({2'b00, tol});
	assign within_c = (err_x >= -tol_x) && (err_x <= tol_x);

	always_ff @(posedge clk) begin
		pi_s2     <= pi_c;
		pp_s2     <= pp_c;
		pd_s2     <= pd_c;
		err_s2    <= err_s1;
		within_s2 <= within_c;
	end

	// stage 2: integral recurrence, truncated toward zero
	assign frac_hi = pi_s2[40:16];
	assign iq      = $signed({{10{integ_q[15]}}, integ_q}) + $signed({frac_hi[24], frac_hi});
	assign i_inc   = iq[25] && (pi_s2[15:0] != 16'd0);
	assign iq_r    = iq + $signed({25'd0, i_inc});
	assign integ_new = sat16($signed({{2{iq_r[25]}}, iq_r}));
	assign kdl_c   = $signed({1'b0, kd}) * last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			last_q  <= '0;
		end else if (ctl.clr) begin
			integ_q <= '0;
			last_q  <= '0;
		end else if (ctl.upd) begin
			integ_q <= integ_new;
			last_q  <= err_s2;
		end
	end

	always_ff @(posedge clk) begin
		integ_s3 <= integ_new;
		pp_s3    <= pp_s2;
		pd_s3    <= pd_s2;
		kdl_s3   <= kdl_c;
	end

	// stage 3: drive sum (kd*(err - last) as kd*err - kd*last)
	assign sum_c = $signed({{2{pp_s3[40]}}, pp_s3}) + $signed({{2{pd_s3[40]}}, pd_s3})
		- $signed({{2{kdl_s3[40]}}, kdl_s3})
		+ $signed({{11{integ_s3[15]}}, integ_s3, 16'd0});

	always_ff @(posedge clk) begin
		sum_s4 <= sum_c;
	end

	// stage 4: truncate and clamp
	assign dq    = sum_s4[42:16];
	assign d_inc = sum_s4[42] && (sum_s4[15:0] != 16'd0);
	assign dq_r  = $signed({dq[26], dq}) + $signed({27'd0, d_inc});
	assign lim_x = $signed({13'd0, limit});

	always_comb begin
		if (dq_r > lim_x) begin
			drive_s4 = lim_x[15:0];
		end else if (dq_r < -lim_x) begin
			drive_s4 = 16'(-lim_x);
		end else begin
			drive_s4 = dq_r[15:0];
		end
	end

endmodule

// ----- rtl/core/dapid_ctrl.sv -----
// Move control: busy flag, tick timeout and merge of both lanes' settle flags.
// Uses dapid_pkg; drives the lanes' integrator control.
module dapid_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                v_s2,
	input  dapid_pkg::cmd_t                     cmd_s2,
	input  logic                                tick_s2,
	input  logic                                within_l,
	input  logic                                within_r,
	input  logic        [dapid_pkg::TICK_W-1:0] timeout,
	output dapid_pkg::lane_ctl_t                ctl,
	output dapid_pkg::res_flags_t               flags_s3
);

	logic                               busy_q;
	logic [dapid_pkg::TICK_W-1:0]       ticks_q;
	logic [dapid_pkg::TICK_W-1:0]       ticks_dec;
	logic                               arrived;
	logic                               done;
	dapid_pkg::res_flags_t              flags_c;

	assign arrived   = within_l && within_r;
	assign ticks_dec = (tick_s2 && (ticks_q != '0)) ? ticks_q - 1'b1 : ticks_q;

	always_comb begin
		ctl.clr = v_s2 && (cmd_s2 == dapid_pkg::CMD_START);
		ctl.upd = v_s2 && (cmd_s2 == dapid_pkg::CMD_SAMPLE) && busy_q;
		done    = ctl.upd && (arrived || (ticks_dec == '0));
		flags_c.done   = done;
		flags_c.tmo    = done && !arrived;
		flags_c.clr    = ctl.clr || done;
		flags_c.moving = ctl.clr || (ctl.upd && !done);
		flags_c.run    = ctl.upd && !done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			ticks_q <= '0;
		end else if (ctl.clr) begin
			busy_q  <= 1'b1;
			ticks_q <= timeout;
		end else if (ctl.upd) begin
			busy_q  <= !done;
			ticks_q <= ticks_dec;
		end
	end

	always_ff @(posedge clk) begin
		flags_s3 <= flags_c;
	end

endmodule

// ----- rtl/core/dapid_ofifo.sv -----
// Result queue between the lane pipeline and the output channel.
// Uses dapid_pkg::res_t; depth set by the top level.
module dapid_ofifo #(
	parameter int DEPTH = dapid_pkg::OUT_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  dapid_pkg::res_t wr_data,
	input  logic            rd_en,
	output logic            rd_valid,
	output dapid_pkg::res_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	dapid_pkg::res_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/dual_axis_position_pid_unit.sv -----
// Accepted items pass stages s1 to s4 and then the result queue to the output channel.
// Throughput: one item per cycle unless stalled; lanes and move control fully pipelined.
// The input stalls once OUT_DEPTH items are accepted and not yet delivered (result queue).
// Reset clears gains to defaults, goals, integrators, busy and the result queue.
// Top level of the dual axis position PID unit; uses dapid_pkg, dapid_lane,
// dapid_ctrl and dapid_ofifo.
module dual_axis_position_pid_unit #(
	parameter int OUT_DEPTH = dapid_pkg::OUT_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic        [dapid_pkg::CFG_IW-1:0] cfg_index,
	input  logic        [dapid_pkg::CFG_DW-1:0] cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic signed [dapid_pkg::TGT_W-1:0]  target_left,
	input  logic signed [dapid_pkg::TGT_W-1:0]  target_right,
	input  logic signed [dapid_pkg::ERR_W-1:0]  enc_left,
	input  logic signed [dapid_pkg::ERR_W-1:0]  enc_right,
	input  logic                                tick,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [dapid_pkg::DRV_W-1:0]  drive_left,
	output logic signed [dapid_pkg::DRV_W-1:0]  drive_right,
	output logic                                move_done,
	output logic                                timed_out,
	output logic                                clear_counts,
	output logic                                moving
);

	localparam int OCC_W = $clog2(OUT_DEPTH + 1);

	logic [dapid_pkg::GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [dapid_pkg::LIM_W-1:0]  limit_q, tol_q;
	logic [dapid_pkg::TICK_W-1:0] timeout_q;

	logic in_acc, out_acc, load_goal;
	logic [OCC_W-1:0] occ_q;

	logic v_s1, v_s2, v_s3, v_s4;
	dapid_pkg::cmd_t cmd_s1, cmd_s2;
	logic tick_s1, tick_s2;

	dapid_pkg::lane_ctl_t  ctl;
	dapid_pkg::res_flags_t flags_s3, flags_s4;
	logic within_l_s2, within_r_s2;
	logic signed [dapid_pkg::DRV_W-1:0] drv_l_s4, drv_r_s4;

	dapid_pkg::res_t wr_res, rd_res;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q      <= dapid_pkg::KP_RST;
			ki_q      <= dapid_pkg::KI_RST;
			kd_q      <= dapid_pkg::KD_RST;
			limit_q   <= dapid_pkg::LIMIT_RST;
			tol_q     <= dapid_pkg::TOL_RST;
			timeout_q <= dapid_pkg::TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dapid_pkg::REG_KP:      kp_q      <= cfg_data[dapid_pkg::GAIN_W-1:0];
				dapid_pkg::REG_KI:      ki_q      <= cfg_data[dapid_pkg::GAIN_W-1:0];
				dapid_pkg::REG_KD:      kd_q      <= cfg_data[dapid_pkg::GAIN_W-1:0];
				dapid_pkg::REG_LIMIT:   limit_q   <= cfg_data[dapid_pkg::LIM_W-1:0];
				dapid_pkg::REG_TOL:     tol_q     <= cfg_data[dapid_pkg::LIM_W-1:0];
				dapid_pkg::REG_TIMEOUT: timeout_q <= cfg_data[dapid_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake and occupancy
	assign in_stall  = (occ_q == OCC_W'(OUT_DEPTH));
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign load_goal = in_acc && (command == dapid_pkg::CMD_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			unique case ({in_acc, out_acc})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1   <= dapid_pkg::cmd_t'(command);
		cmd_s2   <= cmd_s1;
		tick_s1  <= tick;
		tick_s2  <= tick_s1;
		flags_s4 <= flags_s3;
	end

	dapid_lane u_lane_l (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_goal (load_goal),
		.target    (target_left),
		.enc       (enc_left),
		.kp        (kp_q),
		.ki        (ki_q),
		.kd        (kd_q),
		.tol       (tol_q),
		.limit     (limit_q),
		.ctl       (ctl),
		.within_s2 (within_l_s2),
		.drive_s4  (drv_l_s4)
	);

	dapid_lane u_lane_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_goal (load_goal),
		.target    (target_right),
		.enc       (enc_right),
		.kp        (kp_q),
		.ki        (ki_q),
		.kd        (kd_q),
		.tol       (tol_q),
		.limit     (limit_q),
		.ctl       (ctl),
		.within_s2 (within_r_s2),
		.drive_s4  (drv_r_s4)
	);

	dapid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s2     (v_s2),
		.cmd_s2   (cmd_s2),
		.tick_s2  (tick_s2),
		.within_l (within_l_s2),
		.within_r (within_r_s2),
		.timeout  (timeout_q),
		.ctl      (ctl),
		.flags_s3 (flags_s3)
	);

	always_comb begin
		wr_res.drive_left  = flags_s4.run ? drv_l_s4 : '0;
		wr_res.drive_right = flags_s4.run ? drv_r_s4 : '0;
		wr_res.flags       = flags_s4;
	end

	dapid_ofifo #(
		.DEPTH (OUT_DEPTH)
	) u_ofifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (v_s4),
		.wr_data  (wr_res),
		.rd_en    (out_acc),
		.rd_valid (out_valid),
		.rd_data  (rd_res)
	);

	assign drive_left   = rd_res.drive_left;
	assign drive_right  = rd_res.drive_right;
	assign move_done    = rd_res.flags.done;
	assign timed_out    = rd_res.flags.tmo;
	assign clear_counts = rd_res.flags.clr;
	assign moving       = rd_res.flags.moving;

endmodule

// ----- rtl/core/dapid_checker.sv -----
// Port-level checks for the dual axis position PID unit, bound to the top level.
// Uses dapid_pkg widths.
module dapid_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [dapid_pkg::DRV_W-1:0]  drive_left,
	input logic signed [dapid_pkg::DRV_W-1:0]  drive_right,
	input logic                                move_done,
	input logic                                timed_out,
	input logic                                clear_counts,
	input logic                                moving
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive_left)
			&& $stable(drive_right) && $stable(move_done) && $stable(moving))
		else $error("result changed while stalled");

	a_done_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && move_done |-> clear_counts && !moving
			&& (drive_left == '0) && (drive_right == '0))
		else $error("ending item not zero drive with clear");

	a_tmo_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> move_done)
		else $error("timeout reported without end of move");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !moving |-> (drive_left == '0) && (drive_right == '0))
		else $error("nonzero drive while not moving");

endmodule

bind dual_axis_position_pid_unit dapid_checker u_dapid_checker (.*);

// ----- sim/tb_dual_axis_position_pid_unit.sv -----
// Self-checking bench for dual_axis_position_pid_unit: directed and random moves
// under several gain, limit, tolerance and timeout settings, random stalls on both sides.
// Depends on dapid_pkg and the RTL of the unit.
module tb_dual_axis_position_pid_unit;
	import dapid_pkg::*;

	localparam int STUCK_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 88;
	localparam logic [CFG_IW-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IW-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic signed [DRV_W-1:0] drive_left;
		logic signed [DRV_W-1:0] drive_right;
		logic                    done;
		logic                    tmo;
		logic                    clr;
		logic                    moving;
	} pid_result_t;

	class pid_scoreboard;
		logic [GAIN_W-1:0]       kp, ki, kd;
		logic [LIM_W-1:0]        limit, tol;
		logic [TICK_W-1:0]       timeout;
		logic signed [ERR_W-1:0] goal_l, goal_r, last_l, last_r, integ_l, integ_r;
		logic [TICK_W-1:0]       ticks;
		bit                      busy;
		pid_result_t             due_results[$];
		int                      errors;

		function new();
			kp = KP_RST;
			ki = KI_RST;
			kd = KD_RST;
			limit = LIMIT_RST;
			tol = TOL_RST;
			timeout = TIMEOUT_RST;
			goal_l = '0;
			goal_r = '0;
			last_l = '0;
			last_r = '0;
			integ_l = '0;
			integ_r = '0;
			ticks = '0;
			busy = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
			case (idx)
				REG_KP: kp = data[GAIN_W-1:0];
				REG_KI: ki = data[GAIN_W-1:0];
				REG_KD: kd = data[GAIN_W-1:0];
				REG_LIMIT: limit = data[LIM_W-1:0];
				REG_TOL: tol = data[LIM_W-1:0];
				REG_TIMEOUT: timeout = data[TICK_W-1:0];
				default: ;
			endcase
		endfunction

		function longint sat16(longint v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return v;
		endfunction

		function logic signed [DRV_W-1:0] wheel_drive(input logic signed [ERR_W-1:0] goal,
				input logic signed [ERR_W-1:0] enc, inout logic signed [ERR_W-1:0] integ,
				inout logic signed [ERR_W-1:0] last, output logic signed [ERR_W-1:0] err);
			longint e, acc, d, lim;
			e = sat16(longint'(goal) - longint'(enc));
			acc = (longint'(integ) * 65536 + longint'(ki) * e) / 65536;
			integ = ERR_W'(sat16(acc));
			d = (longint'(kp) * e + longint'(integ) * 65536
				+ longint'(kd) * (e - longint'(last))) / 65536;
			lim = longint'(limit);
			if (d > lim)
				d = lim;
			if (d < -lim)
				d = -lim;
			last = ERR_W'(e);
			err = ERR_W'(e);
			return DRV_W'(d);
		endfunction

		function bit near(logic signed [ERR_W-1:0] e);
			return longint'(e) <= longint'(tol) && longint'(e) >= -longint'(tol);
		endfunction

		function void note_item(cmd_t cmd, logic signed [TGT_W-1:0] tl, logic signed [TGT_W-1:0] tr,
				logic signed [ERR_W-1:0] el, logic signed [ERR_W-1:0] er, logic tk);
			pid_result_t r;
			logic signed [ERR_W-1:0] e_l, e_r;
			bit arrived;
			r = '0;
			if (cmd == CMD_START) begin
				goal_l = {tl, 2'b00};
				goal_r = {tr, 2'b00};
				last_l = '0;
				last_r = '0;
				integ_l = '0;
				integ_r = '0;
				ticks = timeout;
				busy = 1'b1;
				r.clr = 1'b1;
			end else if (busy) begin
				if (tk && ticks != 0)
					ticks = ticks - 1'b1;
				r.drive_left = wheel_drive(goal_l, el, integ_l, last_l, e_l);
				r.drive_right = wheel_drive(goal_r, er, integ_r, last_r, e_r);
				arrived = near(e_l) && near(e_r);
				if (arrived || ticks == 0) begin
					r.drive_left = '0;
					r.drive_right = '0;
					r.done = 1'b1;
					r.tmo = !arrived;
					r.clr = 1'b1;
					busy = 1'b0;
				end
			end
			r.moving = busy;
			due_results.push_back(r);
		endfunction

		function void check_result(pid_result_t got);
			pid_result_t want;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: drive %0d/%0d done %b tmo %b clr %b moving %b",
						got.drive_left, got.drive_right, got.done, got.tmo, got.clr, got.moving);
				return;
			end
			want = due_results.pop_front();
			if (got.drive_left !== want.drive_left || got.drive_right !== want.drive_right
					|| got.done !== want.done || got.tmo !== want.tmo
					|| got.clr !== want.clr || got.moving !== want.moving) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected drive %0d/%0d done %b tmo %b clr %b moving %b, got drive %0d/%0d done %b tmo %b clr %b moving %b",
						want.drive_left, want.drive_right, want.done, want.tmo, want.clr,
						want.moving, got.drive_left, got.drive_right, got.done, got.tmo,
						got.clr, got.moving);
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic command;
	logic signed [TGT_W-1:0] target_left, target_right;
	logic signed [ERR_W-1:0] enc_left, enc_right;
	logic tick;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DRV_W-1:0] drive_left, drive_right;
	logic move_done, timed_out, clear_counts, moving;

	pid_scoreboard sb = new();
	bit in_quiet = 1'b0;
	bit out_quiet = 1'b0;
	int stall_run = 0;
	int stuck = 0;

	dual_axis_position_pid_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.target_left(target_left),
		.target_right(target_right),
		.enc_left(enc_left),
		.enc_right(enc_right),
		.tick(tick),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive_left(drive_left),
		.drive_right(drive_right),
		.move_done(move_done),
		.timed_out(timed_out),
		.clear_counts(clear_counts),
		.moving(moving)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly short, a few long
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_target();
		if ($urandom_range(0, 9) < 7)
			return int'($urandom_range(0, 4000)) - 2000;
		return int'($urandom_range(0, 16382)) - 8191;
	endfunction

	// encoder reading about mag counts off the goal, sometimes anywhere
	function automatic int enc_near(int goal, int mag);
		int v;
		if ($urandom_range(0, 99) < 8)
			return int'($urandom_range(0, 65535)) - 32768;
		v = $urandom_range(0, 1) ? goal - mag : goal + mag;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v;
	endfunction

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(pid_result_t'{drive_left, drive_right, move_done, timed_out,
				clear_counts, moving});
		if ($urandom_range(0, 299) == 0)
			out_quiet = ~out_quiet;
		if (stall_run == 0 && !out_quiet && $urandom_range(0, 99) < 20)
			stall_run = pause_len();
		if (stall_run > 0) begin
			out_stall <= 1'b1;
			stall_run--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("FAIL dual_axis_position_pid_unit");
		$finish;
	end

	task automatic send_item(cmd_t cmd, logic signed [TGT_W-1:0] tl, logic signed [TGT_W-1:0] tr,
			logic signed [ERR_W-1:0] el, logic signed [ERR_W-1:0] er, logic tk);
		int gap;
		gap = (in_quiet || $urandom_range(0, 99) < 50) ? 0 : pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		target_left <= tl;
		target_right <= tr;
		enc_left <= el;
		enc_right <= er;
		tick <= tk;
		do @(posedge clk); while (in_stall);
		sb.note_item(cmd, tl, tr, el, er, tk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// bits above the register width get random junk
	task automatic set_reg(logic [CFG_IW-1:0] idx, int unsigned val, int w);
		logic [CFG_DW-1:0] data;
		data = (CFG_DW'($urandom()) << w) | CFG_DW'(val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic apply_setting(int p);
		case (p)
			1: begin
				set_reg(REG_KP, 24'hFFFFFF, GAIN_W);
				set_reg(REG_KI, 24'hFFFFFF, GAIN_W);
				set_reg(REG_KD, 24'hFFFFFF, GAIN_W);
				set_reg(REG_LIMIT, 32767, LIM_W);
				set_reg(REG_TOL, 0, LIM_W);
				set_reg(REG_TIMEOUT, 65535, TICK_W);
				set_reg(REG_SPARE_A, $urandom(), 0);
				set_reg(REG_SPARE_B, $urandom(), 0);
			end
			2: begin
				set_reg(REG_KP, 0, GAIN_W);
				set_reg(REG_KI, 0, GAIN_W);
				set_reg(REG_KD, 0, GAIN_W);
				set_reg(REG_LIMIT, 0, LIM_W);
				set_reg(REG_TOL, 32767, LIM_W);
				set_reg(REG_TIMEOUT, 0, TICK_W);
			end
			3: begin
				set_reg(REG_KP, $urandom_range(0, 24'h60000), GAIN_W);
				set_reg(REG_KI, $urandom_range(0, 24'h4000), GAIN_W);
				set_reg(REG_KD, $urandom_range(0, 24'h30000), GAIN_W);
				set_reg(REG_LIMIT, $urandom_range(1, 2000), LIM_W);
				set_reg(REG_TOL, $urandom_range(0, 60), LIM_W);
				set_reg(REG_TIMEOUT, $urandom_range(1, 12), TICK_W);
			end
			4: begin
				set_reg(REG_KP, KP_RST, GAIN_W);
				set_reg(REG_KI, $urandom_range(24'h10000, 24'h200000), GAIN_W);
				set_reg(REG_KD, 0, GAIN_W);
				set_reg(REG_LIMIT, 32767, LIM_W);
				set_reg(REG_TOL, TOL_RST, LIM_W);
				set_reg(REG_TIMEOUT, 1, TICK_W);
			end
			default: begin
				set_reg(REG_KP, $urandom_range(0, 24'hFFFFFF), GAIN_W);
				set_reg(REG_KI, $urandom_range(0, 24'hFFFFFF), GAIN_W);
				set_reg(REG_KD, $urandom_range(0, 24'hFFFFFF), GAIN_W);
				set_reg(REG_LIMIT, $urandom_range(0, 32767), LIM_W);
				set_reg(REG_TOL, $urandom_range(0, 200), LIM_W);
				set_reg(REG_TIMEOUT, $urandom_range(1, 40), TICK_W);
			end
		endcase
	endtask

	task automatic run_directed();
		send_item(CMD_SAMPLE, -8191, 8191, 32767, -32768, 1'b1);
		send_item(CMD_START, 8191, -8191, -32768, 32767, 1'b1);
		send_item(CMD_SAMPLE, 0, 0, -32768, 32767, 1'b1);
		send_item(CMD_SAMPLE, -1, -1, 0, 0, 1'b0);
		send_item(CMD_SAMPLE, 0, 0, 32761, -32757, 1'b1);
		send_item(CMD_SAMPLE, 0, 0, 100, 100, 1'b1);
		send_item(CMD_START, -8191, 8191, 0, 0, 1'b0);
		send_item(CMD_START, 100, -100, 0, 0, 1'b0);
		send_item(CMD_SAMPLE, 0, 0, 380, -420, 1'b1);
		send_item(CMD_SAMPLE, 0, 0, 385, -415, 1'b0);
		send_item(CMD_START, 0, 0, 0, 0, 1'b0);
		send_item(CMD_SAMPLE, 0, 0, 16, -15, 1'b1);
		send_item(CMD_SAMPLE, 0, 0, 0, 0, 1'b0);
		send_item(CMD_START, 1, -1, 0, 0, 1'b1);
		send_item(CMD_SAMPLE, 0, 0, -32768, 32767, 1'b0);
		send_item(CMD_SAMPLE, 0, 0, 4, -4, 1'b1);
	endtask

	// mostly whole moves that close in on the goal, some stray items
	task automatic run_random(int n);
		int sent, len, goal_l, goal_r, mag_l, mag_r, t_l, t_r;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) == 0)
				in_quiet = ~in_quiet;
			if ($urandom_range(0, 99) < 80) begin
				t_l = pick_target();
				t_r = pick_target();
				goal_l = t_l * 4;
				goal_r = t_r * 4;
				send_item(CMD_START, TGT_W'(t_l), TGT_W'(t_r), 16'($urandom()), 16'($urandom()),
					1'($urandom()));
				len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 14) : $urandom_range(15, 40);
				mag_l = $urandom_range(0, 4000);
				mag_r = $urandom_range(0, 4000);
				for (int k = 0; k < len; k++) begin
					send_item(CMD_SAMPLE, TGT_W'(pick_target()), TGT_W'(pick_target()),
						ERR_W'(enc_near(goal_l, mag_l)), ERR_W'(enc_near(goal_r, mag_r)),
						1'($urandom()));
					mag_l = mag_l * int'($urandom_range(30, 95)) / 100;
					mag_r = mag_r * int'($urandom_range(30, 95)) / 100;
				end
				sent += len + 1;
			end else begin
				len = $urandom_range(1, 4);
				for (int k = 0; k < len; k++)
					send_item(($urandom_range(0, 4) != 0) ? CMD_SAMPLE : CMD_START,
						TGT_W'(pick_target()), TGT_W'(pick_target()), 16'($urandom()),
						16'($urandom()), 1'($urandom()));
				sent += len;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_KP;
		cfg_data <= '0;
		in_valid <= 1'b0;
		command <= CMD_START;
		target_left <= '0;
		target_right <= '0;
		enc_left <= '0;
		enc_right <= '0;
		tick <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(ITEMS_PER_PHASE);
		for (int p = 1; p <= 5; p++) begin
			drain();
			apply_setting(p);
			run_random(ITEMS_PER_PHASE);
		end
		drain();
		repeat (12) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS dual_axis_position_pid_unit");
		else
			$display("FAIL dual_axis_position_pid_unit");
		$finish;
	end

endmodule
